// File: rtl/floor_plane_affine_texture_mapper_assert.svh
// ---------------------------------------------------------------------------
// Floor mapper assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef FLOOR_PLANE_AFFINE_TEXTURE_MAPPER_ASSERT_SVH
`define FLOOR_PLANE_AFFINE_TEXTURE_MAPPER_ASSERT_SVH
`ifndef SYNTHESIS
// property holds at every edge outside reset
`define FAFM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// a at one edge implies b at the next
`define FAFM_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define FAFM_ASSERT(lbl, clk, rst_n, prop)
`define FAFM_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

// File: rtl/fafm_pkg.sv
// ---------------------------------------------------------------------------
// Floor mapper package
// Shared types and constants of the floor texture mapper.
// ---------------------------------------------------------------------------
package fafm_pkg;

  localparam int CFG_IDX_W = 4;
  localparam int IQ_DEPTH  = 4;
  localparam int OQ_DEPTH  = 2;
  localparam int WALK_W    = 48;
  localparam int DELTA_W   = 40;

  localparam logic [CFG_IDX_W-1:0] REG_COS_ANGLE    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_ANGLE    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SCALE  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X      = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HORIZON      = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 4'd7;

  // input action codes
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_RENDER = 1'b1;

  typedef enum logic [1:0] {
    CLS_WRITE,
    CLS_PIXEL,
    CLS_ROW
  } cls_t;

  typedef struct packed {
    cls_t        cls;
    logic [11:0] tile_index;
    logic [31:0] texel_value;
    logic [10:0] pix_col;
    logic [10:0] pix_row;
  } item_t;

  typedef struct packed {
    logic signed [15:0] cos_angle;
    logic signed [15:0] sin_angle;
    logic signed [31:0] camera_x;
    logic signed [31:0] camera_y;
    logic [23:0]        depth_scale;
    logic [15:0]        scale_x;
    logic signed [10:0] horizon;
    logic [11:0]        screen_width;
  } cfg_t;

  typedef struct packed {
    logic               blank;
    logic [DELTA_W-1:0] delta_x;
    logic [DELTA_W-1:0] delta_y;
    logic [WALK_W-1:0]  walk_x;
    logic [WALK_W-1:0]  walk_y;
  } row_res_t;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic [10:0] x;
    logic [10:0] y;
  } out_item_t;

endpackage

// File: rtl/fafm_front.sv
// ---------------------------------------------------------------------------
// Floor mapper front end
// Accepts items, tags them as tile write, pixel or row start, and queues them.
// ---------------------------------------------------------------------------
module fafm_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  logic            in_action,
  input  logic [11:0]     in_tile_index,
  input  logic [31:0]     in_texel_value,
  input  logic [10:0]     in_pix_col,
  input  logic [10:0]     in_pix_row,
  output fafm_pkg::item_t item,
  output logic            item_valid,
  input  logic            item_pop
);

  localparam int PW = $clog2(fafm_pkg::IQ_DEPTH);
  localparam int CW = $clog2(fafm_pkg::IQ_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(fafm_pkg::IQ_DEPTH);

  fafm_pkg::item_t q_r [fafm_pkg::IQ_DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;
  fafm_pkg::item_t tagged_item;
  logic            wr, rd;

  always_comb begin
    tagged_item.tile_index  = in_tile_index;
    tagged_item.texel_value = in_texel_value;
    tagged_item.pix_col     = in_pix_col;
    tagged_item.pix_row     = in_pix_row;
    if (in_action == fafm_pkg::ACT_WRITE) begin
      tagged_item.cls = fafm_pkg::CLS_WRITE;
    end else if (in_pix_col == 11'd0) begin
      tagged_item.cls = fafm_pkg::CLS_ROW;
    end else begin
      tagged_item.cls = fafm_pkg::CLS_PIXEL;
    end
  end

  assign full       = (cnt_r == DEPTH_C);
  assign item_valid = (cnt_r != '0);
  assign item       = q_r[rp_r];
  assign wr         = push && !full;
  assign rd         = item_pop && item_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= tagged_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= PW'((32'(wp_r) + 1) % fafm_pkg::IQ_DEPTH);
      if (rd) rp_r <= PW'((32'(rp_r) + 1) % fafm_pkg::IQ_DEPTH);
      cnt_r <= cnt_r + CW'(wr) - CW'(rd);
    end
  end

endmodule

// File: rtl/fafm_row.sv
// ---------------------------------------------------------------------------
// Floor mapper row setup engine
// Per-row distance, step, deltas and start point on a shared bit-serial
// divider and a shared shift-add multiplier.
// ---------------------------------------------------------------------------
module fafm_row #(
  parameter int MAX_SCREEN = 2048
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fafm_pkg::cfg_t     cfg,
  input  logic               start,
  input  logic [10:0]        row,
  output fafm_pkg::row_res_t res,
  output logic               done
);

  localparam logic [12:0] MAX_W = 13'(MAX_SCREEN);

  typedef enum logic [3:0] {
    R_IDLE, R_DIV1, R_DIV2, R_MDX, R_MDY, R_MPX, R_MPY, R_MHX, R_MHY
  } rstate_t;

  rstate_t            st_r;
  logic [39:0]        q_r;
  logic [15:0]        rem_r, dvs_r;
  logic [5:0]         cnt_r;
  logic [31:0]        dist_r;
  logic [39:0]        step_r;
  logic [55:0]        mcand_r, acc_r;
  logic [15:0]        mplr_r;
  logic [39:0]        dx_r, dy_r;
  logic [47:0]        px_r, py_r, hx_r;
  fafm_pkg::row_res_t res_r;
  logic               done_r;

  logic signed [12:0] row_s, hz_s, denom;
  logic               blank_row;
  logic [16:0]        rem2, rem_sub;
  logic               ge;
  logic [15:0]        rem_nxt;
  logic [39:0]        q_shift;
  logic [55:0]        acc_add;
  logic [41:0]        shr;
  logic [15:0]        cos_mag, sin_mag, sx_eff;
  logic [12:0]        w_sat;
  logic [15:0]        half;
  logic [47:0]        base_x, base_y;

  always_comb begin
    row_s     = $signed({2'b00, row});
    hz_s      = 13'(cfg.horizon);
    denom     = row_s + hz_s;
    blank_row = (row_s < hz_s) || (denom <= 13'sd0);
    rem2      = {rem_r, q_r[39]};
    rem_sub   = rem2 - {1'b0, dvs_r};
    ge        = (rem2 >= {1'b0, dvs_r});
    rem_nxt   = ge ? rem_sub[15:0] : rem2[15:0];
    q_shift   = {q_r[38:0], ge};
    acc_add   = acc_r + (mplr_r[0] ? mcand_r : 56'd0);
    shr       = acc_add[55:14];
    cos_mag   = cfg.cos_angle[15] ? 16'(-cfg.cos_angle) : cfg.cos_angle;
    sin_mag   = cfg.sin_angle[15] ? 16'(-cfg.sin_angle) : cfg.sin_angle;
    sx_eff    = (cfg.scale_x == 16'd0) ? 16'd1 : cfg.scale_x;
    w_sat     = ({1'b0, cfg.screen_width} > MAX_W) ? MAX_W : {1'b0, cfg.screen_width};
    half      = {4'b0, w_sat[12:1]};
    base_x    = {{8{cfg.camera_x[31]}}, cfg.camera_x, 8'b0};
    base_y    = {{8{cfg.camera_y[31]}}, cfg.camera_y, 8'b0};
  end

  assign res  = res_r;
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= R_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (st_r != R_IDLE && st_r != R_DIV1 && st_r != R_DIV2) begin
        acc_r   <= acc_add;
        mcand_r <= {mcand_r[54:0], 1'b0};
        mplr_r  <= {1'b0, mplr_r[15:1]};
        cnt_r   <= cnt_r - 6'd1;
      end
      unique case (st_r)
        R_IDLE: begin
          if (start) begin
            if (blank_row) begin
              res_r.blank <= 1'b1;
              done_r      <= 1'b1;
            end else begin
              q_r   <= {8'b0, cfg.depth_scale, 8'b0};
              rem_r <= '0;
              dvs_r <= {4'b0, denom[11:0]};
              cnt_r <= 6'd39;
              st_r  <= R_DIV1;
            end
          end
        end
        R_DIV1: begin
          q_r   <= q_shift;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            dist_r <= q_shift[31:0];
            q_r    <= {q_shift[31:0], 8'b0};
            rem_r  <= '0;
            dvs_r  <= sx_eff;
            cnt_r  <= 6'd39;
            st_r   <= R_DIV2;
          end
        end
        R_DIV2: begin
          q_r   <= q_shift;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) begin
            step_r  <= q_shift;
            mcand_r <= {16'b0, q_shift};
            mplr_r  <= sin_mag;
            acc_r   <= '0;
            cnt_r   <= 6'd15;
            st_r    <= R_MDX;
          end
        end
        R_MDX: begin
          if (cnt_r == 6'd0) begin
            dx_r    <= cfg.sin_angle[15] ? shr[39:0] : 40'(-shr);
            mcand_r <= {16'b0, step_r};
            mplr_r  <= cos_mag;
            acc_r   <= '0;
            cnt_r   <= 6'd15;
            st_r    <= R_MDY;
          end
        end
        R_MDY: begin
          if (cnt_r == 6'd0) begin
            dy_r    <= cfg.cos_angle[15] ? 40'(-shr) : shr[39:0];
            mcand_r <= {24'b0, dist_r};
            mplr_r  <= cos_mag;
            acc_r   <= '0;
            cnt_r   <= 6'd15;
            st_r    <= R_MPX;
          end
        end
        R_MPX: begin
          if (cnt_r == 6'd0) begin
            px_r    <= cfg.cos_angle[15] ? 48'(-shr) : 48'(shr);
            mcand_r <= {24'b0, dist_r};
            mplr_r  <= sin_mag;
            acc_r   <= '0;
            cnt_r   <= 6'd15;
            st_r    <= R_MPY;
          end
        end
        R_MPY: begin
          if (cnt_r == 6'd0) begin
            py_r    <= cfg.sin_angle[15] ? 48'(-shr) : 48'(shr);
            mcand_r <= {{16{dx_r[39]}}, dx_r};
            mplr_r  <= half;
            acc_r   <= '0;
            cnt_r   <= 6'd15;
            st_r    <= R_MHX;
          end
        end
        R_MHX: begin
          if (cnt_r == 6'd0) begin
            hx_r    <= acc_add[47:0];
            mcand_r <= {{16{dy_r[39]}}, dy_r};
            mplr_r  <= half;
            acc_r   <= '0;
            cnt_r   <= 6'd15;
            st_r    <= R_MHY;
          end
        end
        R_MHY: begin
          if (cnt_r == 6'd0) begin
            res_r.blank   <= 1'b0;
            res_r.delta_x <= dx_r;
            res_r.delta_y <= dy_r;
            res_r.walk_x  <= base_x + px_r - hx_r;
            res_r.walk_y  <= base_y + py_r - acc_add[47:0];
            done_r        <= 1'b1;
            st_r          <= R_IDLE;
          end
        end
        default: st_r <= R_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/fafm_back.sv
// ---------------------------------------------------------------------------
// Floor mapper back end
// Tile store, row walk, texel fetch and result queue.
// ---------------------------------------------------------------------------
`include "floor_plane_affine_texture_mapper_assert.svh"

module fafm_back #(
  parameter int TILE_SIZE = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fafm_pkg::item_t      item,
  input  logic                 item_valid,
  output logic                 item_pop,
  output logic                 row_start,
  output logic [10:0]          row,
  input  fafm_pkg::row_res_t   row_res,
  input  logic                 row_done,
  output logic                 empty,
  input  logic                 pop,
  output fafm_pkg::out_item_t  out_item
);

  localparam int TW    = (TILE_SIZE > 1) ? $clog2(TILE_SIZE) : 1;
  localparam int WORDS = TILE_SIZE * TILE_SIZE;
  localparam int AW    = $clog2(WORDS);
  localparam logic [TW-1:0] TMASK = TW'(TILE_SIZE - 1);
  localparam int OPW   = (fafm_pkg::OQ_DEPTH > 1) ? $clog2(fafm_pkg::OQ_DEPTH) : 1;
  localparam int OCW   = $clog2(fafm_pkg::OQ_DEPTH + 1);
  localparam logic [OCW-1:0] OQ_FULL = OCW'(fafm_pkg::OQ_DEPTH);

  typedef enum logic [1:0] {B_IDLE, B_ROW, B_PIX, B_EMIT} bstate_t;

  bstate_t                      st_r;
  logic [10:0]                  cur_x_r, cur_y_r, row_r;
  logic                         row_start_r;
  logic [fafm_pkg::WALK_W-1:0]  walk_x_r, walk_y_r;
  logic [fafm_pkg::DELTA_W-1:0] delta_x_r, delta_y_r;
  logic                         blank_r;
  logic [31:0]                  mem [WORDS];
  logic [31:0]                  rd_q_r;
  fafm_pkg::out_item_t          oq_r [fafm_pkg::OQ_DEPTH];
  logic [OPW-1:0]               owp_r, orp_r;
  logic [OCW-1:0]               ocnt_r;

  logic            we, re, opush, opop;
  logic [AW-1:0]   waddr, raddr;
  logic [31:0]     int_x, int_y;
  logic [TW-1:0]   tx, ty;
  fafm_pkg::out_item_t res_item;

  always_comb begin
    // truncate toward zero: negative with a fraction rounds up
    int_x = walk_x_r[47:16] + 32'(walk_x_r[47] && (walk_x_r[15:0] != 16'd0));
    int_y = walk_y_r[47:16] + 32'(walk_y_r[47] && (walk_y_r[15:0] != 16'd0));
    tx    = int_x[TW-1:0] & TMASK;
    ty    = int_y[TW-1:0] & TMASK;
    raddr = AW'(AW'(ty) * AW'(TILE_SIZE) + AW'(tx));
    waddr = AW'(item.tile_index);
    we    = (st_r == B_IDLE) && item_valid && (item.cls == fafm_pkg::CLS_WRITE)
            && (32'(item.tile_index) < 32'(WORDS));
    re    = (st_r == B_PIX) && !blank_r;
    res_item.pixel_value = blank_r ? 32'd0 : rd_q_r;
    res_item.x           = cur_x_r;
    res_item.y           = cur_y_r;
  end

  assign item_pop  = (st_r == B_IDLE) && item_valid;
  assign row_start = row_start_r;
  assign row       = row_r;
  assign opush     = (st_r == B_EMIT) && (ocnt_r != OQ_FULL);
  assign opop      = pop && !empty;
  assign empty     = (ocnt_r == '0);
  assign out_item  = oq_r[orp_r];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= item.texel_value;
    if (re) rd_q_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (opush) oq_r[owp_r] <= res_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      row_start_r <= 1'b0;
      walk_x_r    <= '0;
      walk_y_r    <= '0;
      delta_x_r   <= '0;
      delta_y_r   <= '0;
      blank_r     <= 1'b1;
      owp_r       <= '0;
      orp_r       <= '0;
      ocnt_r      <= '0;
    end else begin
      row_start_r <= 1'b0;
      if (opush) owp_r <= OPW'((32'(owp_r) + 1) % fafm_pkg::OQ_DEPTH);
      if (opop)  orp_r <= OPW'((32'(orp_r) + 1) % fafm_pkg::OQ_DEPTH);
      ocnt_r <= ocnt_r + OCW'(opush) - OCW'(opop);
      unique case (st_r)
        B_IDLE: begin
          if (item_valid) begin
            cur_x_r <= item.pix_col;
            cur_y_r <= item.pix_row;
            unique case (item.cls)
              fafm_pkg::CLS_WRITE: st_r <= B_IDLE;
              fafm_pkg::CLS_ROW: begin
                row_r       <= item.pix_row;
                row_start_r <= 1'b1;
                st_r        <= B_ROW;
              end
              fafm_pkg::CLS_PIXEL: st_r <= B_PIX;
              default: st_r <= B_IDLE;
            endcase
          end
        end
        B_ROW: begin
          if (row_done) begin
            blank_r <= row_res.blank;
            if (!row_res.blank) begin
              walk_x_r  <= row_res.walk_x;
              walk_y_r  <= row_res.walk_y;
              delta_x_r <= row_res.delta_x;
              delta_y_r <= row_res.delta_y;
            end
            st_r <= B_PIX;
          end
        end
        B_PIX: begin
          if (!blank_r) begin
            walk_x_r <= walk_x_r + {{8{delta_x_r[39]}}, delta_x_r};
            walk_y_r <= walk_y_r + {{8{delta_y_r[39]}}, delta_y_r};
          end
          st_r <= B_EMIT;
        end
        B_EMIT: begin
          if (opush) st_r <= B_IDLE;
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  `FAFM_ASSERT(a_done_in_row, clk, rst_n, !row_done || (st_r == B_ROW))
  `FAFM_ASSERT(a_oq_bound, clk, rst_n, ocnt_r <= OQ_FULL)
  `FAFM_ASSERT_NEXT(a_pix_then_emit, clk, rst_n, st_r == B_PIX, st_r == B_EMIT)

endmodule

// File: rtl/floor_plane_affine_texture_mapper.sv
// ---------------------------------------------------------------------------
// Perspective floor texture mapper
// Renders a textured floor plane one pixel per item from a square tile store.
// ---------------------------------------------------------------------------
// Channel  Handshake            Payload
// input    push / full          in_action, in_tile_index, in_texel_value,
//                               in_pix_col, in_pix_row
// result   empty / pop          out_pixel_value, out_x, out_y
// config   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Tile write: taken in the back end's idle state; pixel: issue, tile read, transfer.
// A pixel in column 0 first runs row setup: 2 x 40 divider steps and
// 6 x 16 multiplier steps; a blank row skips them.
// Reset (rst_n low, synchronous) empties both queues; tile store kept.
// cfg_ready is always high.
// A full result queue stalls the back end only; the input queue takes four.
// ---------------------------------------------------------------------------
module floor_plane_affine_texture_mapper #(
  parameter int TILE_SIZE  = 64,
  parameter int MAX_SCREEN = 2048
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           push,
  output logic                           full,
  input  logic                           in_action,
  input  logic [11:0]                    in_tile_index,
  input  logic [31:0]                    in_texel_value,
  input  logic [10:0]                    in_pix_col,
  input  logic [10:0]                    in_pix_row,
  // result channel
  output logic                           empty,
  input  logic                           pop,
  output logic [31:0]                    out_pixel_value,
  output logic [10:0]                    out_x,
  output logic [10:0]                    out_y,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fafm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  fafm_pkg::cfg_t      cfg_r;
  fafm_pkg::item_t     item;
  logic                item_valid, item_pop;
  logic                row_start, row_done;
  logic [10:0]         row;
  fafm_pkg::row_res_t  row_res;
  fafm_pkg::out_item_t out_item;

  assign cfg_ready = 1'b1;

  // register file; the host must write only while nothing is in flight (the block does not enforce this)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cos_angle    <= 16'sd16384;
      cfg_r.sin_angle    <= 16'sd0;
      cfg_r.camera_x     <= 32'sd0;
      cfg_r.camera_y     <= 32'sd2560;
      cfg_r.depth_scale  <= 24'd640000;
      cfg_r.scale_x      <= 16'd12800;
      cfg_r.horizon      <= 11'sd20;
      cfg_r.screen_width <= 12'd1280;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fafm_pkg::REG_COS_ANGLE:    cfg_r.cos_angle    <= cfg_data[15:0];
        fafm_pkg::REG_SIN_ANGLE:    cfg_r.sin_angle    <= cfg_data[15:0];
        fafm_pkg::REG_CAMERA_X:     cfg_r.camera_x     <= cfg_data;
        fafm_pkg::REG_CAMERA_Y:     cfg_r.camera_y     <= cfg_data;
        fafm_pkg::REG_DEPTH_SCALE:  cfg_r.depth_scale  <= cfg_data[23:0];
        fafm_pkg::REG_SCALE_X:      cfg_r.scale_x      <= cfg_data[15:0];
        fafm_pkg::REG_HORIZON:      cfg_r.horizon      <= cfg_data[10:0];
        fafm_pkg::REG_SCREEN_WIDTH: cfg_r.screen_width <= cfg_data[11:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // front: classify and queue
  fafm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_action      (in_action),
    .in_tile_index  (in_tile_index),
    .in_texel_value (in_texel_value),
    .in_pix_col     (in_pix_col),
    .in_pix_row     (in_pix_row),
    .item           (item),
    .item_valid     (item_valid),
    .item_pop       (item_pop)
  );

  // per-row setup math
  fafm_row #(
    .MAX_SCREEN (MAX_SCREEN)
  ) u_row (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .start (row_start),
    .row   (row),
    .res   (row_res),
    .done  (row_done)
  );

  // back: walk, texel fetch, result queue
  fafm_back #(
    .TILE_SIZE (TILE_SIZE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .row_start  (row_start),
    .row        (row),
    .row_res    (row_res),
    .row_done   (row_done),
    .empty      (empty),
    .pop        (pop),
    .out_item   (out_item)
  );

  assign out_pixel_value = out_item.pixel_value;
  assign out_x           = out_item.x;
  assign out_y           = out_item.y;

endmodule

// File: tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// Floor texture mapper testbench
// Streams tile writes and raster pixels through the push/pop queues, walks a
// set of camera and projection settings, and checks every rendered pixel
// against a fixed-point floor projection kept inside the bench.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int  TILE       = 64;
  localparam int  TILE_WORDS = TILE * TILE;
  localparam int  SCREEN_MAX = 2048;
  localparam int  SETTLE     = 400;      // margin for a row setup still in flight
  localparam longint CYCLE_LIMIT = 1000000;

  // Floor projection plus the queue of pixels still owed by the block.
  class floor_scoreboard;
    logic [31:0] texels [TILE_WORDS];
    bit          written [TILE_WORDS];
    longint      cos_a, sin_a, cam_x, cam_y, horizon;
    longint      depth, scl_x, width;
    longint      walk_x, walk_y, step_x, step_y;
    bit          blank;
    fafm_pkg::out_item_t owed [$];
    int          errors;

    function new();
      cos_a = 16384; sin_a = 0; cam_x = 0; cam_y = 2560;
      depth = 640000; scl_x = 12800; horizon = 20; width = 1280;
      walk_x = 0; walk_y = 0; step_x = 0; step_y = 0;
      blank = 1; errors = 0;
    endfunction

    function longint wrap40(longint v);
      logic signed [39:0] t;
      t = v[39:0];
      return t;
    endfunction

    function longint wrap48(longint v);
      logic signed [47:0] t;
      t = v[47:0];
      return t;
    endfunction

    function void set_reg(logic [fafm_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
      case (idx)
        fafm_pkg::REG_COS_ANGLE:    cos_a   = longint'($signed(d[15:0]));
        fafm_pkg::REG_SIN_ANGLE:    sin_a   = longint'($signed(d[15:0]));
        fafm_pkg::REG_CAMERA_X:     cam_x   = longint'($signed(d));
        fafm_pkg::REG_CAMERA_Y:     cam_y   = longint'($signed(d));
        fafm_pkg::REG_DEPTH_SCALE:  depth   = longint'(d[23:0]);
        fafm_pkg::REG_SCALE_X:      scl_x   = longint'(d[15:0]);
        fafm_pkg::REG_HORIZON:      horizon = longint'($signed(d[10:0]));
        fafm_pkg::REG_SCREEN_WIDTH: width   = longint'(d[11:0]);
        default: ;
      endcase
    endfunction

    // Per-row distance, step and start point; state untouched.
    function void row_setup(longint row, output bit blk, output longint dx,
                            output longint dy, output longint wx, output longint wy);
      longint denom, sx, half, distance, stp;
      denom = row + horizon;
      sx    = (scl_x == 0) ? 1 : scl_x;
      half  = ((width > SCREEN_MAX) ? SCREEN_MAX : width) / 2;
      blk = 1; dx = step_x; dy = step_y; wx = walk_x; wy = walk_y;
      if (row < horizon || denom <= 0) return;
      blk      = 0;
      distance = (depth << 8) / denom;
      stp      = (distance * 256) / sx;
      dx = wrap40(-(sin_a * stp) / 16384);
      dy = wrap40((cos_a * stp) / 16384);
      wx = wrap48(cam_x * 256 + (distance * cos_a) / 16384 - half * dx);
      wy = wrap48(cam_y * 256 + (distance * sin_a) / 16384 - half * dy);
    endfunction

    function int texel_addr(longint wx, longint wy);
      longint tx, ty;
      tx = (wx / 65536) & (TILE - 1);
      ty = (wy / 65536) & (TILE - 1);
      return int'(ty * TILE + tx);
    endfunction

    // Tile address a render would read next, or -1 for a blank pixel.
    function int peek_addr(logic [10:0] x, logic [10:0] y);
      bit blk;
      longint dx, dy, wx, wy;
      if (x == 0) row_setup(longint'(y), blk, dx, dy, wx, wy);
      else begin
        blk = blank; wx = walk_x; wy = walk_y;
      end
      return blk ? -1 : texel_addr(wx, wy);
    endfunction

    function void note_input(bit act, logic [11:0] idx, logic [31:0] val,
                             logic [10:0] x, logic [10:0] y);
      fafm_pkg::out_item_t o;
      if (act == fafm_pkg::ACT_WRITE) begin
        if (idx < TILE_WORDS) begin
          texels[idx] = val;
          written[idx] = 1;
        end
        return;
      end
      if (x == 0) row_setup(longint'(y), blank, step_x, step_y, walk_x, walk_y);
      o.pixel_value = '0;
      o.x = x;
      o.y = y;
      if (!blank) begin
        o.pixel_value = texels[texel_addr(walk_x, walk_y)];
        walk_x = wrap48(walk_x + step_x);
        walk_y = wrap48(walk_y + step_y);
      end
      owed.push_back(o);
    endfunction

    function void check(logic [31:0] pix, logic [10:0] x, logic [10:0] y);
      fafm_pkg::out_item_t e;
      if (owed.size() == 0) begin
        $error("unexpected pixel transfer x=%0d y=%0d value=%h", x, y, pix);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (pix !== e.pixel_value) begin
        $error("pixel_value: expected %h, got %h", e.pixel_value, pix);
        errors++;
      end
      if (x !== e.x) begin
        $error("out_x: expected %0d, got %0d", e.x, x);
        errors++;
      end
      if (y !== e.y) begin
        $error("out_y: expected %0d, got %0d", e.y, y);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic push = 0, pop = 0;
  logic full, empty;
  logic        in_action = 0;
  logic [11:0] in_tile_index = '0;
  logic [31:0] in_texel_value = '0;
  logic [10:0] in_pix_col = '0, in_pix_row = '0;
  logic [31:0] out_pixel_value;
  logic [10:0] out_x, out_y;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [fafm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  floor_scoreboard sb = new();
  longint cycles = 0;
  bit     fast_in = 0, fast_out = 0;   // stretches with no idling
  int     sent = 0;

  floor_plane_affine_texture_mapper i_dut (
    .clk, .rst_n, .push, .full, .in_action, .in_tile_index, .in_texel_value,
    .in_pix_col, .in_pix_row, .empty, .pop, .out_pixel_value, .out_x, .out_y,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Runaway guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function int gap_len(bit fast);
    int r;
    if (fast) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Result side: pop held low for random stretches; transfers are checked
  // at the rising edge on the pre-edge values.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        pop <= 0;
      end else begin
        pop <= 1;
        hold = gap_len(fast_out);
      end
      @(posedge clk);
      if (rst_n && pop && !empty) sb.check(out_pixel_value, out_x, out_y);
    end
  end

  // One input transfer; push stays high, gap() lowers it.
  task automatic send(bit act, logic [11:0] idx, logic [31:0] val,
                      logic [10:0] x, logic [10:0] y);
    @(negedge clk);
    push <= 1;
    in_action <= act;
    in_tile_index <= idx;
    in_texel_value <= val;
    in_pix_col <= x;
    in_pix_row <= y;
    do @(posedge clk); while (full);
    sb.note_input(act, idx, val, x, y);
    sent++;
  endtask

  task automatic gap();
    int n;
    n = gap_len(fast_in);
    if (n == 0) return;
    @(negedge clk);
    push <= 0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic write_texel(logic [11:0] idx, logic [31:0] val);
    send(fafm_pkg::ACT_WRITE, idx, val, 11'($urandom), 11'($urandom));
    gap();
  endtask

  // Render one pixel; a texel about to be read for the first time gets a
  // write first so no unwritten entry is ever fetched.
  task automatic render(logic [10:0] x, logic [10:0] y);
    int a;
    a = sb.peek_addr(x, y);
    if (a >= 0 && !sb.written[a]) write_texel(a[11:0], $urandom);
    send(fafm_pkg::ACT_RENDER, 12'($urandom), $urandom, x, y);
    gap();
  endtask

  // Let every owed pixel drain, then cover a row setup still in flight.
  task automatic drain();
    @(negedge clk);
    push <= 0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [fafm_pkg::CFG_IDX_W-1:0] idx, logic [31:0] d);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // Random setting; extreme picks one value from each corner now and then.
  task automatic random_setting(bit extreme);
    logic [31:0] v;
    v = extreme ? ($urandom_range(1) ? 32'hFFFF_C000 : 32'h0000_4000)
                : $signed($urandom_range(32768)) - 16384;
    write_reg(fafm_pkg::REG_COS_ANGLE, v);
    v = extreme ? ($urandom_range(1) ? 32'hFFFF_C000 : 32'h0000_4000)
                : $signed($urandom_range(32768)) - 16384;
    write_reg(fafm_pkg::REG_SIN_ANGLE, v);
    write_reg(fafm_pkg::REG_CAMERA_X,
              extreme ? ($urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF) : $urandom);
    write_reg(fafm_pkg::REG_CAMERA_Y,
              extreme ? ($urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF) : $urandom);
    write_reg(fafm_pkg::REG_DEPTH_SCALE,
              extreme ? ($urandom_range(1) ? 32'hFF_FFFF : 32'h0)
                      : $urandom_range(24'hFF_FFFF));
    write_reg(fafm_pkg::REG_SCALE_X,
              extreme ? ($urandom_range(1) ? 32'hFFFF : 32'h0)
                      : $urandom_range(16'hFFFF));
    write_reg(fafm_pkg::REG_HORIZON,
              extreme ? ($urandom_range(1) ? 32'h400 : 32'h3FF)
                      : $urandom_range(11'h7FF));
    write_reg(fafm_pkg::REG_SCREEN_WIDTH,
              extreme ? ($urandom_range(1) ? 32'hFFF : 32'h0)
                      : $urandom_range(12'hFFF));
  endtask

  initial begin
    int rows, len;
    logic [10:0] y;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed: reset settings, blank pixel before any row start, a row
    // above the horizon, a normal row, the last row and column.
    render(11'd5, 11'd3);
    render(11'd0, 11'd0);
    render(11'd1, 11'd0);
    write_texel(12'd0, 32'h0000_0000);
    write_texel(12'hFFF, 32'hFFFF_FFFF);
    for (int x = 0; x < 4; x++) render(x[10:0], 11'd100);
    render(11'd2047, 11'd100);          // past the row width, walk keeps going
    render(11'd7, 11'd2047);            // mid-row entry with another row number
    render(11'd0, 11'd2047);
    render(11'd2047, 11'd2047);
    drain();

    // Extreme corners: negative horizon, zero scale, oversized width.
    write_reg(fafm_pkg::REG_HORIZON, 32'h400);
    write_reg(fafm_pkg::REG_SCALE_X, 32'h0);
    write_reg(fafm_pkg::REG_SCREEN_WIDTH, 32'hFFF);
    render(11'd0, 11'd500);
    render(11'd1, 11'd500);
    render(11'd0, 11'd1100);
    render(11'd1, 11'd1100);
    drain();

    // Random phases: mostly well formed rows with random settings.
    for (int ph = 0; sent < 860; ph++) begin
      random_setting(ph % 4 == 1);
      fast_in = (ph % 5 == 2);
      fast_out = (ph % 5 == 3);
      rows = $urandom_range(10, 4);
      for (int r = 0; r < rows; r++) begin
        y = 11'($urandom);
        len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
        for (int x = 0; x < len; x++) begin
          if ($urandom_range(9) == 0) write_texel(12'($urandom), $urandom);
          render(x[10:0], y);
        end
        if ($urandom_range(4) == 0) render(11'($urandom), 11'($urandom));   // stray pixel
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: floor_plane_affine_texture_mapper.f
+incdir+rtl
rtl/fafm_pkg.sv
rtl/fafm_front.sv
rtl/fafm_row.sv
rtl/fafm_back.sv
rtl/floor_plane_affine_texture_mapper.sv
tb/sv/tb_top.sv
